>>> hdl/i2ra_pkg.sv
// ----------------------------------------------------------------------------
// i2ra_pkg: shared definitions for the integer to radix text converter
// widths, digit cell geometry, ascii codes and the digit to character map
// ----------------------------------------------------------------------------
package i2ra_pkg;

  // input value width, two's complement
  localparam int unsigned VALUE_BITS = 64;
  // magnitude after saturation of the most negative value
  localparam int unsigned MAG_BITS = VALUE_BITS - 1;

  // digit cells, enough for radix two of the full magnitude
  localparam int unsigned DIGITS = 64;
  localparam int unsigned DIGIT_IDX_W = $clog2(DIGITS);
  localparam int unsigned DIGIT_CNT_W = $clog2(DIGITS + 1);

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  // bit counter for the shift-in phase
  localparam int unsigned BIT_CNT_W = $clog2(MAG_BITS);
  // one alignment step per bit of the shift amount
  localparam int unsigned ALIGN_STEPS = DIGIT_IDX_W;
  localparam int unsigned ALIGN_CNT_W = $clog2(ALIGN_STEPS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

  // digit 0..9 -> '0'..'9', 10..35 -> 'A'..'Z'
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_UPPER_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

>>> hdl/integer_to_radix_ascii_core.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core: signed integer to base-n ascii text
// converts one signed value and a radix (2..36) into its ascii text,
// most significant character first, one character per output word
// ----------------------------------------------------------------------------
// usage
//   input channel: value_i / radix_i with in_valid_i, in_stall_o. a word is
//   taken when in_valid_i is high and in_stall_o is low. in_stall_o stays
//   high from the accepted word until its last character is loaded into the
//   output register, so one value is converted at a time
//   output channel: character_o / last_o with out_valid_o, out_stall_i. one
//   word per character, a leading '-' for negative values, last_o high on
//   the final character. out_stall_i freezes the output register; the
//   sequencer simply waits in its emit phase
//   timing: the magnitude is shifted in through the shared digit cell
//   row, the alignment steps then left-justify the digits, then the
//   characters (sign plus 1..63 digits) are emitted, waiting while the
//   output is stalled; the digit cell row takes one magnitude bit per
//   cycle, so the magnitude width sets the shift-in length
//   radix codes below 2 act as 2, above 36 act as 36; the most negative
//   value is written as the text of its neighbor toward zero
//   reset: asynchronous, clears the sequencer and the output valid; no
//   memory to clear, the block is ready the first cycle after reset
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input words
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [i2ra_pkg::VALUE_BITS-1:0] value_i,
  input  logic        [i2ra_pkg::RADIX_W-1:0]    radix_i,
  // output words
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic        [i2ra_pkg::CHAR_W-1:0]     character_o,
  output logic                                  last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_ALIGN,
    ST_EMIT
  } state_e;

  localparam int unsigned NCARRY = i2ra_pkg::DIGITS + 1;

  // control state
  state_e                                 state_q, state_d;
  logic [i2ra_pkg::BIT_CNT_W-1:0]         bit_cnt_q, bit_cnt_d;
  logic [i2ra_pkg::ALIGN_CNT_W-1:0]       align_cnt_q, align_cnt_d;
  logic [i2ra_pkg::DIGIT_CNT_W-1:0]       ndig_q, ndig_d;
  logic [i2ra_pkg::DIGIT_CNT_W-1:0]       rem_q, rem_d;
  logic                                   out_valid_q, out_valid_d;
  logic [i2ra_pkg::CHAR_W-1:0]            char_q, char_d;
  logic                                   last_q, last_d;

  // datapath registers
  logic [i2ra_pkg::DIGIT_W-1:0]           cells_q [i2ra_pkg::DIGITS];
  logic [i2ra_pkg::DIGIT_W-1:0]           cells_d [i2ra_pkg::DIGITS];
  logic [i2ra_pkg::MAG_BITS-1:0]          mag_q, mag_d;
  logic [i2ra_pkg::RADIX_W-1:0]           radix_q, radix_d;
  logic                                   neg_q, neg_d;
  logic [i2ra_pkg::DIGIT_IDX_W-1:0]       shamt_q, shamt_d;

  // shared digit cell row: doubling with radix carry, lookahead carries
  logic [i2ra_pkg::DIGITS-1:0]            gen, prop;
  logic [NCARRY-1:0]                      carry_sum, carry_in;
  logic [i2ra_pkg::DIGIT_W-1:0]           cell_next [i2ra_pkg::DIGITS];
  logic [i2ra_pkg::DIGIT_W:0]             dbl, cell_sum;
  logic                                   cell_out;
  logic                                   bit_in;

  // fixed power-of-two shifts for the alignment steps
  logic [i2ra_pkg::DIGIT_W-1:0]           cand [i2ra_pkg::ALIGN_STEPS][i2ra_pkg::DIGITS];

  logic                                   in_take;
  logic                                   out_free;
  logic                                   neg_in;
  logic [i2ra_pkg::VALUE_BITS-1:0]        abs_in;
  logic [i2ra_pkg::DIGIT_CNT_W-1:0]       ndig_fin;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  assign bit_in = mag_q[i2ra_pkg::MAG_BITS-1];

  // per cell: generate when 2d alone reaches the radix, propagate when
  // 2d+1 equals it; the carry chain is a single wide add
  always_comb begin
    for (int i = 0; i < i2ra_pkg::DIGITS; i++) begin
      dbl     = {cells_q[i], 1'b0};
      gen[i]  = dbl >= {1'b0, radix_q};
      prop[i] = (dbl + 7'd1) == {1'b0, radix_q};
    end
    carry_sum = {1'b0, gen | prop} + {1'b0, gen} + NCARRY'(bit_in);
    carry_in  = carry_sum ^ {1'b0, gen | prop} ^ {1'b0, gen};
    for (int i = 0; i < i2ra_pkg::DIGITS; i++) begin
      dbl          = {cells_q[i], 1'b0};
      cell_out     = gen[i] | (prop[i] & carry_in[i]);
      cell_sum     = dbl + 7'(carry_in[i])
                     - (cell_out ? {1'b0, radix_q} : 7'd0);
      cell_next[i] = cell_sum[i2ra_pkg::DIGIT_W-1:0];
    end
  end

  always_comb begin
    for (int l = 0; l < i2ra_pkg::ALIGN_STEPS; l++) begin
      for (int i = 0; i < i2ra_pkg::DIGITS; i++) begin
        if (i >= (1 << l)) begin
          cand[l][i] = cells_q[i - (1 << l)];
        end else begin
          cand[l][i] = '0;
        end
      end
    end
  end

  // input magnitude with saturation of the most negative value
  assign neg_in = value_i[i2ra_pkg::VALUE_BITS-1];
  assign abs_in = neg_in ? (~value_i + 1'b1) : value_i;

  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    align_cnt_d = align_cnt_q;
    ndig_d      = ndig_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    cells_d     = cells_q;
    mag_d       = mag_q;
    radix_d     = radix_q;
    neg_d       = neg_q;
    shamt_d     = shamt_q;
    ndig_fin    = ndig_q;

    // output word leaves
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if (radix_i < i2ra_pkg::RADIX_MIN) begin
            radix_d = i2ra_pkg::RADIX_MIN;
          end else if (radix_i > i2ra_pkg::RADIX_MAX) begin
            radix_d = i2ra_pkg::RADIX_MAX;
          end else begin
            radix_d = radix_i;
          end
          neg_d = neg_in;
          if (abs_in[i2ra_pkg::VALUE_BITS-1]) begin
            mag_d = '1;
          end else begin
            mag_d = abs_in[i2ra_pkg::MAG_BITS-1:0];
          end
          for (int i = 0; i < i2ra_pkg::DIGITS; i++) begin
            cells_d[i] = '0;
          end
          ndig_d    = '0;
          bit_cnt_d = i2ra_pkg::BIT_CNT_W'(i2ra_pkg::MAG_BITS - 1);
          state_d   = ST_CONV;
        end
      end

      ST_CONV: begin
        cells_d = cell_next;
        mag_d   = {mag_q[i2ra_pkg::MAG_BITS-2:0], 1'b0};
        // a carry into the first unused cell opens a new digit
        if (carry_in[ndig_q]) begin
          ndig_d = ndig_q + 1'b1;
        end
        if (bit_cnt_q == '0) begin
          // zero still prints one digit
          ndig_fin    = (ndig_d == '0) ? i2ra_pkg::DIGIT_CNT_W'(1) : ndig_d;
          ndig_d      = ndig_fin;
          rem_d       = ndig_fin;
          shamt_d     = i2ra_pkg::DIGIT_IDX_W'(i2ra_pkg::DIGITS - ndig_fin);
          align_cnt_d = i2ra_pkg::ALIGN_CNT_W'(i2ra_pkg::ALIGN_STEPS - 1);
          state_d     = ST_ALIGN;
        end else begin
          bit_cnt_d = bit_cnt_q - 1'b1;
        end
      end

      ST_ALIGN: begin
        // most significant digit ends in the top cell
        if (shamt_q[align_cnt_q]) begin
          cells_d = cand[align_cnt_q];
        end
        if (align_cnt_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          align_cnt_d = align_cnt_q - 1'b1;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            char_d = i2ra_pkg::CHAR_MINUS;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            char_d = i2ra_pkg::digit_to_char(cells_q[i2ra_pkg::DIGITS-1]);
            last_d = (rem_q == i2ra_pkg::DIGIT_CNT_W'(1));
            for (int i = 0; i < i2ra_pkg::DIGITS; i++) begin
              cells_d[i] = (i == 0) ? '0 : cells_q[(i == 0) ? 0 : i - 1];
            end
            rem_d = rem_q - 1'b1;
            if (rem_q == i2ra_pkg::DIGIT_CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      align_cnt_q <= '0;
      ndig_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      align_cnt_q <= align_cnt_d;
      ndig_q      <= ndig_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      last_q      <= last_d;
      neg_q       <= neg_d;
    end
  end

  // digit cells and operands
  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    mag_q   <= mag_d;
    radix_q <= radix_d;
    shamt_q <= shamt_d;
  end

  // checks
  a_ndig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndig_q <= i2ra_pkg::DIGIT_CNT_W'(i2ra_pkg::MAG_BITS))
    else $error("digit count beyond magnitude width");

  a_emit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (rem_q != '0))
    else $error("emit phase with no digits left");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("output word raised outside emit phase");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && !neg_q && rem_q == i2ra_pkg::DIGIT_CNT_W'(1))
      |=> (state_q == ST_IDLE && last_q && out_valid_q))
    else $error("final character did not end the conversion");

endmodule

>>> dv/i2ra_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2ra_checker: output text checker for the integer to radix text converter
// watches both channels, builds the expected characters of every accepted
// value and compares each accepted output word against the oldest one
// ----------------------------------------------------------------------------
module i2ra_checker
  import i2ra_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [RADIX_W-1:0]    radix_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [CHAR_W-1:0]     character_i,
  input  logic                  last_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_word_t;

  text_word_t  expected_text[$];
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // appends the characters of one value, most significant first
  function automatic void predict_text(input logic [VALUE_BITS-1:0] value,
                                       input logic [RADIX_W-1:0]    radix);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] base;
    logic [VALUE_BITS-1:0] digit;
    logic [CHAR_W-1:0]     chars[$];
    logic                  negative;
    text_word_t            w;
    if (radix < RADIX_MIN) begin
      base = VALUE_BITS'(RADIX_MIN);
    end else if (radix > RADIX_MAX) begin
      base = VALUE_BITS'(RADIX_MAX);
    end else begin
      base = VALUE_BITS'(radix);
    end
    negative = value[VALUE_BITS-1];
    mag = negative ? ~value + 1'b1 : value;
    // most negative value: clamp to the largest positive magnitude
    if (mag[VALUE_BITS-1]) begin
      mag = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
    do begin
      digit = mag % base;
      if (digit < VALUE_BITS'(DEC_DIGITS)) begin
        chars.push_front(CHAR_ZERO + CHAR_W'(digit));
      end else begin
        chars.push_front(CHAR_UPPER_A + CHAR_W'(digit - VALUE_BITS'(DEC_DIGITS)));
      end
      mag = mag / base;
    end while (mag != 0);
    if (negative) begin
      chars.push_front(CHAR_MINUS);
    end
    foreach (chars[i]) begin
      w.character = chars[i];
      w.last      = (i == chars.size() - 1);
      expected_text.push_back(w);
    end
  endfunction

  always @(posedge clk_i) begin : watch
    text_word_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected word, character %h last %b",
                                    character_i, last_i));
        end else begin
          want = expected_text.pop_front();
          if (character_i !== want.character) begin
            report_mismatch($sformatf("character %h, expected %h",
                                      character_i, want.character));
          end
          if (last_i !== want.last) begin
            report_mismatch($sformatf("last %b, expected %b on character %h",
                                      last_i, want.last, want.character));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_text(value_i, radix_i);
      end
    end
    pending_o <= expected_text.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the integer to radix text converter
// drives directed and random values and radix codes with random gaps and
// output stalls, one long output hold-off, and reports the checker verdict
// ----------------------------------------------------------------------------
module tb_top;
  import i2ra_pkg::*;

  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned RANDOM_WORDS  = 430;
  localparam int unsigned IDLE_PCT      = 28;
  // random words sent back to back, no sender gaps
  localparam int unsigned CALM_FIRST    = 150;
  localparam int unsigned CALM_LAST     = 260;
  // receiver cycles with no stall at all
  localparam int unsigned RX_CALM_FIRST = 20000;
  localparam int unsigned RX_CALM_LAST  = 28000;
  // long receiver hold-off so the block backs up into its input
  localparam int unsigned HOLD_AT       = 5000;
  localparam int unsigned HOLD_CYCLES   = 600;
  // shift-in plus alignment plus a full 64 character text, with margin
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  localparam logic [VALUE_BITS-1:0] POS_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] NEG_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [VALUE_BITS-1:0] value_i     = '0;
  logic [RADIX_W-1:0]    radix_i     = RADIX_MIN;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CHAR_W-1:0]     character_o;
  logic                  last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  integer_to_radix_ascii_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .radix_i     (radix_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  i2ra_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .value_i      (value_i),
    .radix_i      (radix_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .character_i  (character_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit, far beyond the slowest legal run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // offers one input word, holds it until taken, then maybe idles a while.
  // valid is only lowered in the idle loop, so back to back words keep it
  // high without a second assignment in the same step
  task automatic send_word(input logic [VALUE_BITS-1:0] value,
                           input logic [RADIX_W-1:0]    radix,
                           input bit                    calm);
    value_i    <= value;
    radix_i    <= radix;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        value_i    <= VALUE_BITS'({$urandom, $urandom});
        @(posedge clk_i);
      end
    end
  endtask

  // mix of raw patterns, short and long magnitudes, all-ones runs and the
  // most negative value, either sign
  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] v;
    int unsigned           pick;
    v = VALUE_BITS'({$urandom, $urandom});
    pick = $urandom_range(0, 15);
    case (pick)
      0, 1, 2: ;
      3, 4:    v = VALUE_BITS'($urandom_range(0, 1000));
      5:       v = POS_MAX >> $urandom_range(0, VALUE_BITS - 1);
      6:       v = NEG_MIN;
      7:       v = POS_MAX;
      8, 9:    v = v >> $urandom_range(32, VALUE_BITS - 1);
      default: v = v >> $urandom_range(1, VALUE_BITS - 1);
    endcase
    if (pick > 2 && pick != 6 && $urandom_range(0, 1)) begin
      v = -v;
    end
    return v;
  endfunction

  // mostly legal bases, sometimes any 6-bit code to hit the clamps
  function automatic logic [RADIX_W-1:0] random_radix();
    if ($urandom_range(0, 99) < 85) begin
      return RADIX_W'($urandom_range(2, 36));
    end
    return RADIX_W'($urandom_range(0, 63));
  endfunction

  // receiver stall pattern, counted in its own cycles
  initial begin : receiver
    int unsigned rx_cycle;
    int unsigned hold_left;
    rx_cycle  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle == HOLD_AT) begin
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_cycle >= RX_CALM_FIRST && rx_cycle < RX_CALM_LAST) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero, one and minus one
    send_word('0, RADIX_W'(10), 1'b0);
    send_word(VALUE_BITS'(1), RADIX_W'(2), 1'b0);
    send_word(VALUE_BITS'(-1), RADIX_W'(10), 1'b0);
    // longest texts: binary of the extremes
    send_word(POS_MAX, RADIX_W'(2), 1'b0);
    send_word(-POS_MAX, RADIX_W'(2), 1'b0);
    // most negative value, clamped to its neighbor toward zero
    send_word(NEG_MIN, RADIX_W'(2), 1'b0);
    send_word(NEG_MIN, RADIX_W'(10), 1'b0);
    send_word(NEG_MIN, RADIX_W'(16), 1'b0);
    // top base, highest digit and the first carry into two digits
    send_word(POS_MAX, RADIX_W'(36), 1'b0);
    send_word(-POS_MAX, RADIX_W'(36), 1'b0);
    send_word(VALUE_BITS'(35), RADIX_W'(36), 1'b0);
    send_word(VALUE_BITS'(36), RADIX_W'(36), 1'b0);
    send_word(VALUE_BITS'(-35), RADIX_W'(36), 1'b0);
    // decimal digit boundary and first letter
    send_word(VALUE_BITS'(9), RADIX_W'(10), 1'b0);
    send_word(VALUE_BITS'(-10), RADIX_W'(11), 1'b0);
    send_word(VALUE_BITS'(255), RADIX_W'(16), 1'b0);
    send_word(POS_MAX, RADIX_W'(10), 1'b0);
    // radix codes below two and above thirty-six
    send_word(VALUE_BITS'(5), RADIX_W'(0), 1'b0);
    send_word(VALUE_BITS'(-6), RADIX_W'(1), 1'b0);
    send_word(VALUE_BITS'(71), RADIX_W'(37), 1'b0);
    send_word(VALUE_BITS'(-1295), RADIX_W'(63), 1'b0);
    send_word('0, RADIX_W'(63), 1'b0);
    // alternating bit patterns
    send_word({(VALUE_BITS/2){2'b10}}, RADIX_W'(8), 1'b0);
    send_word({(VALUE_BITS/2){2'b01}}, RADIX_W'(3), 1'b0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      send_word(random_value(), random_radix(), (n >= CALM_FIRST && n < CALM_LAST));
    end
    in_valid_i <= 1'b0;

    // let the checker see the last accept, then drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/i2ra_pkg.sv
hdl/integer_to_radix_ascii_core.sv
dv/i2ra_checker.sv
dv/tb_top.sv
